>>> rtl/core/sem_pkg.sv
package sem_pkg;

	localparam int PIX_W  = 8;
	localparam int CFG_W  = 13;
	localparam int POS_W  = 12;
	localparam int MAG_W  = 8;
	localparam int GRAD_W = 11;
	localparam int OUT_W  = MAG_W + 2 * POS_W;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic signed [GRAD_W-1:0] grad_t;

	typedef struct packed {
		logic             interior;
		logic             last;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
	} pos_ctl_t;

endpackage

>>> rtl/core/sobel_edge_magnitude.sv
// Channel   Direction  Handshake               Payload
// s_*       in         s_tvalid / s_tready     tdata: pixel; tuser: frame_start
// m_*       out        m_tvalid / m_tready     tdata: magnitude, center_col,
//                                              center_row; tlast: frame_last
// cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel per cycle while no result waits on m_tready; after its pixel's transfer a result
// passes the line store read, the gradient stage and the output register, in that order.
// Line stores are one read and one write per pixel; a read of the column just
// being written back is forwarded.
// Reset clears counters, window and valid bits; the line stores are not cleared.
// All stages advance together: s_tready falls only while a result waits on m_tready.
module sobel_edge_magnitude #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [sem_pkg::PIX_W-1:0]  s_tdata,   // [7:0] pixel
	input  logic                       s_tuser,   // [0] frame_start
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [sem_pkg::OUT_W-1:0]  m_tdata,   // [7:0] magnitude, [19:8] center_col,
	                                              // [31:20] center_row
	output logic                       m_tlast,   // frame_last
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [sem_pkg::CFG_W-1:0]  cfg_data
);

	import sem_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
		if (32'(v) < 3) return WW'(3);
		if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
		return WW'(v);
	endfunction

	function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
		if (32'(v) < 3) return HW'(3);
		if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
		return HW'(v);
	endfunction

	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic          adv, accept;
	logic [CW-1:0] c0, cm1;
	logic [RW-1:0] r0, rm1;
	logic [CW:0]   c_inc;
	logic [RW:0]   r_inc;
	pos_ctl_t      ctl0;

	logic          valid_s1, fwd_s1;
	logic [CW-1:0] col_s1;
	pix_t          px_s1, fwd_top_s1, fwd_mid_s1;
	pos_ctl_t      ctl_s1;
	pix_t          rd_top, rd_mid, top_eff, mid_eff;

	logic          valid_s2;
	grad_t         gx_s2, gy_s2;
	pos_ctl_t      ctl_s2;

	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = adv;
	assign accept    = s_tvalid && adv;
	assign cfg_ready = 1'b1;

	always_comb begin
		c0    = s_tuser ? '0 : col_q;
		r0    = s_tuser ? '0 : row_q;
		cm1   = c0 - 1'b1;
		rm1   = r0 - 1'b1;
		c_inc = {1'b0, c0} + 1'b1;
		r_inc = {1'b0, r0} + 1'b1;
		ctl0.interior = (c0 >= CW'(2)) && (r0 >= RW'(2)) && (c0 < w_q) && (r0 < h_q);
		ctl0.last     = (c_inc == w_q) && (r_inc == h_q);
		ctl0.col      = POS_W'(cm1);
		ctl0.row      = POS_W'(rm1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= clamp_w(WIDTH_RESET);
			h_q <= clamp_h(HEIGHT_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  w_q <= clamp_w(cfg_data);
				REG_IMAGE_HEIGHT: h_q <= clamp_h(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c_inc >= w_q) begin
				col_q <= '0;
				row_q <= (r_inc >= h_q) ? '0 : r_inc[RW-1:0];
			end else begin
				col_q <= c_inc[CW-1:0];
				row_q <= (r0 >= h_q) ? '0 : r0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			fwd_s1   <= accept && valid_s1 && (col_s1 == c0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1     <= c0;
			px_s1      <= s_tdata;
			ctl_s1     <= ctl0;
			fwd_top_s1 <= mid_eff;
			fwd_mid_s1 <= px_s1;
		end
	end

	assign top_eff = fwd_s1 ? fwd_top_s1 : rd_top;
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : rd_mid;

	sem_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_two_above (
		.clk   (clk),
		.we    (valid_s1 && adv),
		.waddr (col_s1),
		.wdata (mid_eff),
		.re    (accept),
		.raddr (c0),
		.rdata (rd_top)
	);

	sem_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_above (
		.clk   (clk),
		.we    (valid_s1 && adv),
		.waddr (col_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (c0),
		.rdata (rd_mid)
	);

	sem_kernel u_kernel (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.px_s1    (px_s1),
		.top_s1   (top_eff),
		.mid_s1   (mid_eff),
		.ctl_s1   (ctl_s1),
		.valid_s2 (valid_s2),
		.gx_s2    (gx_s2),
		.gy_s2    (gy_s2),
		.ctl_s2   (ctl_s2)
	);

	sem_mag u_mag (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s2 (valid_s2),
		.gx_s2    (gx_s2),
		.gy_s2    (gy_s2),
		.ctl_s2   (ctl_s2),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> rtl/core/sem_ram.sv
module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/sem_kernel.sv
module sem_kernel (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              valid_s1,
	input  sem_pkg::pix_t     px_s1,
	input  sem_pkg::pix_t     top_s1,
	input  sem_pkg::pix_t     mid_s1,
	input  sem_pkg::pos_ctl_t ctl_s1,
	output logic              valid_s2,
	output sem_pkg::grad_t    gx_s2,
	output sem_pkg::grad_t    gy_s2,
	output sem_pkg::pos_ctl_t ctl_s2
);

	import sem_pkg::*;

	pix_t  win_q [6];
	grad_t t0, m0, b0, t1, b1, tp, md, pv;
	grad_t gx, gy;
	logic  valid_s2_q;

	always_comb begin
		t0 = $signed({3'b000, win_q[0]});
		m0 = $signed({3'b000, win_q[1]});
		b0 = $signed({3'b000, win_q[2]});
		t1 = $signed({3'b000, win_q[3]});
		b1 = $signed({3'b000, win_q[5]});
		tp = $signed({3'b000, top_s1});
		md = $signed({3'b000, mid_s1});
		pv = $signed({3'b000, px_s1});
		gx = (tp - t0) + ((md - m0) <<< 1) + (pv - b0);
		gy = (b0 + (b1 <<< 1) + pv) - (t0 + (t1 <<< 1) + tp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2_q <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			valid_s2_q <= valid_s1 & ctl_s1.interior;
			if (valid_s1) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= top_s1;
				win_q[4] <= mid_s1;
				win_q[5] <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s2  <= gx;
			gy_s2  <= gy;
			ctl_s2 <= ctl_s1;
		end
	end

	assign valid_s2 = valid_s2_q;

endmodule

>>> rtl/core/sem_mag.sv
module sem_mag (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       valid_s2,
	input  sem_pkg::grad_t             gx_s2,
	input  sem_pkg::grad_t             gy_s2,
	input  sem_pkg::pos_ctl_t          ctl_s2,
	output logic                       m_tvalid,
	output logic [sem_pkg::OUT_W-1:0]  m_tdata,
	output logic                       m_tlast
);

	import sem_pkg::*;

	logic [GRAD_W-1:0] ax, ay, sum;
	logic [GRAD_W-2:0] half;
	logic [MAG_W-1:0]  mag;
	logic              valid_q;
	logic [MAG_W-1:0]  mag_q;
	logic [POS_W-1:0]  col_q, row_q;
	logic              last_q;

	always_comb begin
		ax   = gx_s2[GRAD_W-1] ? GRAD_W'(-gx_s2) : GRAD_W'(gx_s2);
		ay   = gy_s2[GRAD_W-1] ? GRAD_W'(-gy_s2) : GRAD_W'(gy_s2);
		sum  = ax + ay;
		half = sum[GRAD_W-1:1];
		mag  = (half > (GRAD_W-1)'((1 << MAG_W) - 1)) ? '1 : half[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			mag_q  <= mag;
			col_q  <= ctl_s2.col;
			row_q  <= ctl_s2.row;
			last_q <= ctl_s2.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {row_q, col_q, mag_q};
	assign m_tlast  = last_q;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import sem_pkg::*;

	localparam int MAX_W = DEF_MAX_WIDTH;
	localparam int MAX_H = DEF_MAX_HEIGHT;
	localparam int RANDOM_ITEMS = 900;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int FILL_W = 24;

	typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_FLAT} texture_t;
	typedef enum int {SEG_FRAME, SEG_NO_START, SEG_BROKEN, SEG_NOISE} segment_t;

	typedef struct packed {
		logic       fs;
		pix_t       px;
	} pixel_item_t;

	typedef struct packed {
		logic             idx;
		logic [CFG_W-1:0] value;
	} reg_write_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             last;
	} edge_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [PIX_W-1:0]  s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tlast;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0]  cfg_data = '0;

	sobel_edge_magnitude u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	pixel_item_t  pixel_queue[$];
	reg_write_t   reg_writes[$];
	edge_result_t pending_edges[$];

	pixel_item_t head_pixel;
	reg_write_t  head_write;
	int unsigned pixels_queued = 0;
	int unsigned pixels_taken = 0;
	int unsigned writes_queued = 0;
	int unsigned writes_taken = 0;
	int unsigned edges_checked = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned src_gap = 0;
	int unsigned sink_stall = 0;
	bit          quiet = 1'b0;

	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	pix_t             above_row[MAX_W];
	pix_t             two_up_row[MAX_W];
	pix_t             win_px[6];
	int unsigned      col_pos;
	int unsigned      row_pos;

	function automatic int unsigned fit_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
		if (v < 3) return 3;
		if (int'(v) > hi) return hi;
		return int'(v);
	endfunction

	task automatic clear_edge_state();
		width_reg = CFG_W'(640);
		height_reg = CFG_W'(480);
		for (int i = 0; i < MAX_W; i++) begin
			above_row[i] = '0;
			two_up_row[i] = '0;
		end
		for (int i = 0; i < 6; i++) win_px[i] = '0;
		col_pos = 0;
		row_pos = 0;
	endtask

	task automatic predict_pixel(input pix_t px, input logic fs);
		int unsigned  w, h, c, r;
		int           gx, gy, mag;
		pix_t         top, mid;
		edge_result_t res;
		w = fit_dim(width_reg, MAX_W);
		h = fit_dim(height_reg, MAX_H);
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		top = '0;
		mid = '0;
		if (c < MAX_W) begin
			top = two_up_row[c];
			mid = above_row[c];
			two_up_row[c] = mid;
			above_row[c] = px;
		end
		if (c >= 2 && r >= 2 && c < w && r < h) begin
			gx = (int'(top) - int'(win_px[0])) + 2 * (int'(mid) - int'(win_px[1]))
				+ (int'(px) - int'(win_px[2]));
			gy = (int'(win_px[2]) + 2 * int'(win_px[5]) + int'(px))
				- (int'(win_px[0]) + 2 * int'(win_px[3]) + int'(top));
			mag = ((gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy)) / 2;
			if (mag > 255) mag = 255;
			res.mag = MAG_W'(mag);
			res.col = POS_W'(c - 1);
			res.row = POS_W'(r - 1);
			res.last = (c == w - 1 && r == h - 1);
			pending_edges.push_back(res);
		end
		win_px[0] = win_px[3];
		win_px[1] = win_px[4];
		win_px[2] = win_px[5];
		win_px[3] = top;
		win_px[4] = mid;
		win_px[5] = px;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end else if (r >= h) begin
			r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	task automatic report_field(input string field, input int want, input int got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
		end
	endtask

	task automatic check_edge(input edge_result_t got);
		edge_result_t want;
		if (pending_edges.size() == 0) begin
			error_count++;
			$display("%0t: unexpected result, expected none actual mag %0d col %0d row %0d last %0d",
				$time, got.mag, got.col, got.row, got.last);
		end else begin
			want = pending_edges.pop_front();
			edges_checked++;
			report_field("magnitude", want.mag, got.mag);
			report_field("center_col", want.col, got.col);
			report_field("center_row", want.row, got.row);
			report_field("frame_last", want.last, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_pixel(s_tdata, s_tuser);
				pixels_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pixel_queue.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 15) == 0) begin
					src_gap <= $urandom_range(0, 18);
					s_tvalid <= 1'b0;
				end else begin
					head_pixel = pixel_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= head_pixel.px;
					s_tuser <= head_pixel.fs;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= REG_IMAGE_WIDTH;
			cfg_data <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
				writes_taken++;
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_writes.size() != 0) begin
					head_write = reg_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= head_write.idx;
					cfg_data <= head_write.value;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_stall <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_edge({m_tdata[MAG_W-1:0], m_tdata[MAG_W +: POS_W],
					m_tdata[MAG_W+POS_W +: POS_W], m_tlast});
			if (sink_stall != 0) begin
				sink_stall <= sink_stall - 1;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				sink_stall <= $urandom_range(0, 18);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still awaited", $time, pending_edges.size());
			$display("sobel_edge_magnitude test failed");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pixels_taken != pixels_queued || pending_edges.size() != 0
				|| writes_taken != writes_queued)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		wait_idle();
		reg_writes.push_back('{idx: REG_IMAGE_WIDTH, value: w});
		reg_writes.push_back('{idx: REG_IMAGE_HEIGHT, value: h});
		writes_queued += 2;
		while (writes_taken != writes_queued) @(posedge clk);
	endtask

	function automatic pix_t pick_pixel(input texture_t tex);
		case (tex)
			TEXTURE_NOISE:  return pix_t'($urandom_range(0, 255));
			TEXTURE_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default:        return pix_t'(120 + $urandom_range(0, 3));
		endcase
	endfunction

	task automatic push_run(input int unsigned count, input texture_t tex,
			input bit start_first, input int unsigned start_odds);
		pixel_item_t item;
		for (int unsigned i = 0; i < count; i++) begin
			item.px = pick_pixel(tex);
			item.fs = (start_first && i == 0)
				|| (start_odds != 0 && $urandom_range(1, start_odds) == 1);
			pixel_queue.push_back(item);
			pixels_queued++;
		end
	endtask

	initial begin
		logic [CFG_W-1:0] raw_w, raw_h;
		int unsigned      frame_px, len, pick, random_items;
		segment_t         kind;
		texture_t         tex;
		pixel_item_t      item;

		clear_edge_state();
		random_items = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every line store column that the random frames can reach
		set_size(CFG_W'(FILL_W), 13'd3);
		push_run(FILL_W * 3, TEXTURE_NOISE, 1'b1, 0);

		set_size(13'd5, 13'd5);
		for (int i = 0; i < 25; i++) begin
			item.px = ((i % 5 >= 2) ^ (i / 5 >= 2)) ? 8'hFF : 8'h00;
			item.fs = (i == 0);
			pixel_queue.push_back(item);
			pixels_queued++;
		end

		while (random_items < RANDOM_ITEMS) begin
			if (random_items > RANDOM_ITEMS - 150) quiet = 1'b1;
			raw_w = CFG_W'($urandom_range(3, FILL_W));
			raw_h = CFG_W'($urandom_range(3, 9));
			if ($urandom_range(0, 7) == 0) raw_w = CFG_W'($urandom_range(0, 2));
			if ($urandom_range(0, 7) == 0) raw_h = CFG_W'($urandom_range(0, 2));
			set_size(raw_w, raw_h);
			frame_px = fit_dim(raw_w, MAX_W) * fit_dim(raw_h, MAX_H);
			repeat ($urandom_range(1, 4)) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) kind = SEG_FRAME;
				else if (pick == 7) kind = SEG_NO_START;
				else if (pick == 8) kind = SEG_BROKEN;
				else kind = SEG_NOISE;
				pick = $urandom_range(0, 2);
				tex = (pick == 0) ? TEXTURE_NOISE : (pick == 1) ? TEXTURE_BINARY : TEXTURE_FLAT;
				case (kind)
					SEG_FRAME: begin
						len = frame_px;
						push_run(len, tex, 1'b1, 0);
					end
					SEG_NO_START: begin
						len = frame_px;
						push_run(len, tex, 1'b0, 0);
					end
					SEG_BROKEN: begin
						len = $urandom_range(1, frame_px - 1);
						push_run(len, tex, 1'b1, 0);
					end
					default: begin
						len = $urandom_range(1, 30);
						push_run(len, tex, 1'b0, 4);
					end
				endcase
				random_items += len;
			end
		end

		wait_idle();
		$display("small frames, clamped sizes, size changes between runs, restarts");
		$display("and missing frame starts: %0d pixels, %0d results, %0d writes",
			pixels_taken, edges_checked, writes_taken);
		if (error_count == 0)
			$display("sobel_edge_magnitude test passed");
		else
			$display("sobel_edge_magnitude test failed");
		$finish;
	end

endmodule
